// ----- design/pcf_pkg.sv -----
// Shared types, constants and CRC helpers for the PNG chunk framer.
`default_nettype none

package pcf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    localparam int LEN_W = 31;
    localparam int IDX_W = 4;

    localparam logic [IDX_W-1:0] FIRST_IDX        = 4'd0;
    localparam logic [IDX_W-1:0] TYPE_FIRST_IDX   = 4'd4;
    localparam logic [IDX_W-1:0] HDR_LAST_IDX     = 4'd7;
    localparam logic [IDX_W-1:0] HDR_CRC_FIRST    = 4'd8;
    localparam logic [IDX_W-1:0] HDR_CRC_LAST_IDX = 4'd11;
    localparam logic [IDX_W-1:0] PAY_CRC_FIRST    = 4'd1;
    localparam logic [IDX_W-1:0] PAY_CRC_LAST_IDX = 4'd4;

    typedef enum logic
    {
        REQ_HEADER  = 1'b0,
        REQ_PAYLOAD = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic             req_type;
        logic [31:0]      chunk_type;
        logic [LEN_W-1:0] chunk_length;
        logic [7:0]       data_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       chunk_end;
        logic       seq_error;
        logic       last_result;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b & BYTE_MASK};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = CRC_POLY ^ (c >> 1);
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] crc_sel(input logic [31:0] v, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/png_chunk_framer_crc32_core.sv -----
// PNG chunk framer: header and payload transactions in, framed chunk bytes with CRC-32 out.
// result_valid rises when an accepted transaction's first byte moves to the output register.
// The output gives one result per cycle while result_ready holds; a payload byte yields one
// result (five on the last byte) and a header eight (twelve for a zero-length chunk).
// The CRC advances one byte per cycle as type and payload bytes move to the output.
// Reset (rst_n low, asynchronous): no chunk open, CRC all ones, both stages empty.
`default_nettype none

module png_chunk_framer_crc32_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output      logic            item_ready,
    input  wire pcf_pkg::item_t  item,
    output      logic            result_valid,
    input  wire logic            result_ready,
    output      pcf_pkg::result_t result
);
    import pcf_pkg::*;

    logic             desc_valid_reg, desc_valid_next;
    logic [IDX_W-1:0] desc_idx_reg, desc_idx_next;
    logic [IDX_W-1:0] desc_last_reg, desc_last_next;
    logic             desc_hdr_reg, desc_hdr_next;
    logic             desc_nobyte_reg, desc_nobyte_next;
    logic             desc_err_reg, desc_err_next;
    logic             desc_crc_reg, desc_crc_next;
    logic [7:0]       desc_bytes_reg [8];

    logic [31:0]      crc_acc_reg, crc_acc_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic             chunk_open_reg, chunk_open_next;

    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic             move;
    logic             desc_done;
    logic             accept;
    logic             at_last;
    logic             in_crc;
    logic [IDX_W-1:0] crc_pos;
    logic [LEN_W-1:0] left_dec;
    logic [7:0]       cur_byte;

    assign move       = desc_valid_reg && (!result_valid_reg || result_ready);
    assign at_last    = desc_idx_reg == desc_last_reg;
    assign desc_done  = move && at_last;
    assign item_ready = !desc_valid_reg || desc_done;
    assign accept     = item_valid && item_ready;
    assign left_dec   = bytes_left_reg - {{(LEN_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        chunk_open_next  = chunk_open_reg;
        bytes_left_next  = bytes_left_reg;
        desc_last_next   = desc_last_reg;
        desc_hdr_next    = desc_hdr_reg;
        desc_nobyte_next = desc_nobyte_reg;
        desc_err_next    = desc_err_reg;
        desc_crc_next    = desc_crc_reg;
        if (accept)
        begin
            desc_nobyte_next = 1'b0;
            desc_err_next    = 1'b0;
            desc_crc_next    = 1'b0;
            if (item.req_type == REQ_HEADER)
            begin
                desc_hdr_next = 1'b1;
                desc_err_next = chunk_open_reg;
                if (item.chunk_length == '0)
                begin
                    chunk_open_next = 1'b0;
                    bytes_left_next = '0;
                    desc_crc_next   = 1'b1;
                    desc_last_next  = HDR_CRC_LAST_IDX;
                end
                else
                begin
                    chunk_open_next = 1'b1;
                    bytes_left_next = item.chunk_length;
                    desc_last_next  = HDR_LAST_IDX;
                end
            end
            else if (!chunk_open_reg)
            begin
                desc_hdr_next    = 1'b0;
                desc_nobyte_next = 1'b1;
                desc_err_next    = 1'b1;
                desc_last_next   = FIRST_IDX;
            end
            else
            begin
                desc_hdr_next   = 1'b0;
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    chunk_open_next = 1'b0;
                    desc_crc_next   = 1'b1;
                    desc_last_next  = PAY_CRC_LAST_IDX;
                end
                else
                begin
                    desc_last_next = FIRST_IDX;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            desc_valid_next = 1'b1;
        else if (desc_done)
            desc_valid_next = 1'b0;
        else
            desc_valid_next = desc_valid_reg;

        if (accept)
            desc_idx_next = FIRST_IDX;
        else if (move)
            desc_idx_next = desc_idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
        else
            desc_idx_next = desc_idx_reg;
    end

    // Select the byte for the current descriptor position
    always_comb
    begin
        if (desc_hdr_reg)
        begin
            in_crc  = desc_idx_reg >= HDR_CRC_FIRST;
            crc_pos = desc_idx_reg - HDR_CRC_FIRST;
        end
        else
        begin
            in_crc  = desc_idx_reg >= PAY_CRC_FIRST;
            crc_pos = desc_idx_reg - PAY_CRC_FIRST;
        end

        if (in_crc)
            cur_byte = crc_sel(crc_acc_reg ^ CRC_ONES, crc_pos[1:0]);
        else if (desc_nobyte_reg)
            cur_byte = 8'd0;
        else
            cur_byte = desc_bytes_reg[desc_idx_reg[2:0]];

        result_next.out_byte    = cur_byte;
        result_next.byte_valid  = !desc_nobyte_reg;
        result_next.chunk_end   = desc_crc_reg && at_last;
        result_next.seq_error   = desc_err_reg && (desc_idx_reg == FIRST_IDX);
        result_next.last_result = at_last;
    end

    // Advance the CRC as type and payload bytes leave; reseed it at header start and chunk end
    always_comb
    begin
        crc_acc_next = crc_acc_reg;
        if (move)
        begin
            if (desc_crc_reg && at_last)
                crc_acc_next = CRC_ONES;
            else if (desc_hdr_reg && desc_idx_reg == FIRST_IDX)
                crc_acc_next = CRC_ONES;
            else if (desc_hdr_reg && !in_crc && desc_idx_reg >= TYPE_FIRST_IDX)
                crc_acc_next = crc_byte(crc_acc_reg, cur_byte);
            else if (!desc_hdr_reg && !desc_nobyte_reg && desc_idx_reg == FIRST_IDX)
                crc_acc_next = crc_byte(crc_acc_reg, cur_byte);
        end
    end

    always_comb
    begin
        if (move)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg   <= 1'b0;
            desc_idx_reg     <= FIRST_IDX;
            desc_last_reg    <= FIRST_IDX;
            desc_hdr_reg     <= 1'b0;
            desc_nobyte_reg  <= 1'b0;
            desc_err_reg     <= 1'b0;
            desc_crc_reg     <= 1'b0;
            crc_acc_reg      <= CRC_ONES;
            bytes_left_reg   <= '0;
            chunk_open_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            desc_valid_reg   <= desc_valid_next;
            desc_idx_reg     <= desc_idx_next;
            desc_last_reg    <= desc_last_next;
            desc_hdr_reg     <= desc_hdr_next;
            desc_nobyte_reg  <= desc_nobyte_next;
            desc_err_reg     <= desc_err_next;
            desc_crc_reg     <= desc_crc_next;
            crc_acc_reg      <= crc_acc_next;
            bytes_left_reg   <= bytes_left_next;
            chunk_open_reg   <= chunk_open_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (item.req_type == REQ_HEADER)
            begin
                desc_bytes_reg[0] <= {1'b0, item.chunk_length[30:24]};
                desc_bytes_reg[1] <= item.chunk_length[23:16];
                desc_bytes_reg[2] <= item.chunk_length[15:8];
                desc_bytes_reg[3] <= item.chunk_length[7:0];
                desc_bytes_reg[4] <= item.chunk_type[31:24];
                desc_bytes_reg[5] <= item.chunk_type[23:16];
                desc_bytes_reg[6] <= item.chunk_type[15:8];
                desc_bytes_reg[7] <= item.chunk_type[7:0];
            end
            else
            begin
                desc_bytes_reg[0] <= item.data_byte;
            end
        end
        if (move)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.chunk_end |-> result.last_result && result.byte_valid)
    else $error("chunk end without last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> desc_idx_reg <= desc_last_reg)
    else $error("descriptor index beyond last position");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.seq_error && result.last_result)
    else $error("empty result that is not a lone error");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.req_type == REQ_PAYLOAD && chunk_open_reg |=> bytes_left_reg == $past(left_dec))
    else $error("payload count did not advance");

endmodule

`default_nettype wire

// ----- sim/tb_png_chunk_framer_crc32_core.sv -----
// Self-checking testbench for the PNG chunk framer with CRC-32.
`timescale 1ns / 1ps

module tb_png_chunk_framer_crc32_core;

    import pcf_pkg::*;

    localparam int MAX_RES     = 12;
    localparam int DIR_N       = 20;
    localparam int RAND_N      = 330;
    localparam int HOLD_CYCLES = 160;
    localparam int DRAIN       = 24;
    localparam int LIMIT       = 300000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed
    {
        item_t   it;
        logic    lit_on;
        result_t lit;
    } step_row_t;

    localparam result_t ERR_LIT = result_t'{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam result_t NO_LIT  = '0;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item_bus;
    logic    result_valid;
    logic    result_ready;
    result_t result_bus;

    logic [31:0] crc_run;
    logic [30:0] pay_left;
    logic        in_chunk;

    result_t   pend [MAX_RES];
    int        pend_n;
    result_t   framed_q [$];
    result_t   want;
    step_row_t dir_tab [DIR_N];

    int   mism_cnt;
    int   rand_cnt;
    int   cyc;
    logic idle_on;
    logic hold_req;

    png_chunk_framer_crc32_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        logic        fb;
        int          i;
        r = c;
        for (i = 0; i < 8; i++)
        begin
            fb = r[0] ^ d[i];
            r  = r >> 1;
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic void add_pend(input logic [7:0] b, input logic v, input logic e,
                                     input logic err);
        pend[pend_n] = result_t'{b, v, e, err, 1'b0};
        pend_n++;
    endfunction

    function automatic void close_chunk();
        logic [31:0] sig;
        int          k;
        sig = crc_run ^ CRC_ONES;
        for (k = 0; k < 4; k++)
            add_pend(sig[31-8*k -: 8], 1'b1, k == 3, 1'b0);
        in_chunk = 1'b0;
        pay_left = '0;
        crc_run  = CRC_ONES;
    endfunction

    function automatic void frame_transaction(input item_t it);
        logic [31:0] len32;
        logic [7:0]  b;
        int          k;
        pend_n = 0;
        if (it.req_type == REQ_HEADER)
        begin
            len32 = {1'b0, it.chunk_length};
            for (k = 0; k < 4; k++)
                add_pend(len32[31-8*k -: 8], 1'b1, 1'b0, (k == 0) && in_chunk);
            crc_run = CRC_ONES;
            for (k = 0; k < 4; k++)
            begin
                b       = it.chunk_type[31-8*k -: 8];
                crc_run = crc32_step(crc_run, b);
                add_pend(b, 1'b1, 1'b0, 1'b0);
            end
            if (it.chunk_length == '0)
                close_chunk();
            else
            begin
                in_chunk = 1'b1;
                pay_left = it.chunk_length;
            end
        end
        else if (!in_chunk)
            add_pend(8'h00, 1'b0, 1'b0, 1'b1);
        else
        begin
            crc_run = crc32_step(crc_run, it.data_byte);
            add_pend(it.data_byte, 1'b1, 1'b0, 1'b0);
            pay_left = pay_left - 31'd1;
            if (pay_left == '0)
                close_chunk();
        end
        pend[pend_n-1].last_result = 1'b1;
    endfunction

    function automatic step_row_t mk_row(input req_kind_t req, input logic [31:0] ty,
                                         input logic [30:0] len, input logic [7:0] d,
                                         input logic lit_on, input result_t lit);
        step_row_t r;
        r.it.req_type     = req;
        r.it.chunk_type   = ty;
        r.it.chunk_length = len;
        r.it.data_byte    = d;
        r.lit_on          = lit_on;
        r.lit             = lit;
        return r;
    endfunction

    function automatic item_t hdr_item(input logic [30:0] len);
        item_t it;
        it.req_type     = REQ_HEADER;
        it.chunk_type   = $urandom;
        it.chunk_length = len;
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    function automatic item_t pay_item();
        item_t it;
        it.req_type     = REQ_PAYLOAD;
        it.chunk_type   = $urandom;
        it.chunk_length = 31'($urandom);
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mism_cnt++;
        if (mism_cnt <= PRINT_CAP)
            $display("mismatch %0d at cycle %0d: %s got %0h, wanted %0h",
                     mism_cnt, cyc, what, got, exp_val);
    endtask

    task automatic send_item(input item_t it, input logic lit_on, input result_t lit);
        int gap;
        int i;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        frame_transaction(it);
        if (lit_on)
            pend[0] = lit;
        for (i = 0; i < pend_n; i++)
            framed_q = {framed_q, pend[i]};
    endtask

    task automatic send_rand(input item_t it);
        if (rand_cnt == 200)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            while (framed_q.size() != 0)
                @(posedge clk);
        end
        if (rand_cnt == 100)
            hold_req = 1'b1;
        if (rand_cnt >= RAND_N - 60)
            idle_on = 1'b0;
        send_item(it, 1'b0, NO_LIT);
        rand_cnt++;
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT)
        begin
            $display("png_chunk_framer_crc32_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (framed_q.size() == 0)
                flag_mismatch("result with nothing pending", 32'(result_bus), 32'd0);
            else
            begin
                want = framed_q.pop_front();
                if (result_bus.out_byte !== want.out_byte)
                    flag_mismatch("out_byte", 32'(result_bus.out_byte), 32'(want.out_byte));
                if (result_bus.byte_valid !== want.byte_valid)
                    flag_mismatch("byte_valid", 32'(result_bus.byte_valid),
                                  32'(want.byte_valid));
                if (result_bus.chunk_end !== want.chunk_end)
                    flag_mismatch("chunk_end", 32'(result_bus.chunk_end), 32'(want.chunk_end));
                if (result_bus.seq_error !== want.seq_error)
                    flag_mismatch("seq_error", 32'(result_bus.seq_error), 32'(want.seq_error));
                if (result_bus.last_result !== want.last_result)
                    flag_mismatch("last_result", 32'(result_bus.last_result),
                                  32'(want.last_result));
            end
        end
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                result_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        int r;
        int pick;
        int len;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item_bus   = '0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        mism_cnt   = 0;
        rand_cnt   = 0;
        cyc        = 0;
        crc_run    = CRC_ONES;
        pay_left   = '0;
        in_chunk   = 1'b0;

        dir_tab[0]  = mk_row(REQ_PAYLOAD, 32'h0000_0000, 31'h0, 8'hA5, 1'b1, ERR_LIT);
        dir_tab[1]  = mk_row(REQ_HEADER, 32'h4945_4E44, 31'h0, 8'h00, 1'b1,
                             result_t'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0});
        dir_tab[2]  = mk_row(REQ_HEADER, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h00, 1'b1,
                             result_t'{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0});
        dir_tab[3]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'hFF, 1'b0, NO_LIT);
        dir_tab[4]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h00, 1'b0, NO_LIT);
        dir_tab[5]  = mk_row(REQ_HEADER, 32'h0000_0000, 31'h3, 8'h00, 1'b1,
                             result_t'{8'h00, 1'b1, 1'b0, 1'b1, 1'b0});
        dir_tab[6]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h00, 1'b0, NO_LIT);
        dir_tab[7]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'hFF, 1'b0, NO_LIT);
        dir_tab[8]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h5A, 1'b0, NO_LIT);
        dir_tab[9]  = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h3C, 1'b1, ERR_LIT);
        dir_tab[10] = mk_row(REQ_HEADER, 32'h4948_4452, 31'h1, 8'h00, 1'b0, NO_LIT);
        dir_tab[11] = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'hFF, 1'b0, NO_LIT);
        dir_tab[12] = mk_row(REQ_HEADER, 32'h4944_4154, 31'h2, 8'h00, 1'b0, NO_LIT);
        dir_tab[13] = mk_row(REQ_HEADER, 32'h4945_4E44, 31'h0, 8'h00, 1'b1,
                             result_t'{8'h00, 1'b1, 1'b0, 1'b1, 1'b0});
        dir_tab[14] = mk_row(REQ_HEADER, 32'h7445_5874, 31'h0102_0304, 8'h00, 1'b1,
                             result_t'{8'h01, 1'b1, 1'b0, 1'b0, 1'b0});
        dir_tab[15] = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h80, 1'b0, NO_LIT);
        dir_tab[16] = mk_row(REQ_HEADER, 32'h8000_0001, 31'h4000_0000, 8'h00, 1'b1,
                             result_t'{8'h40, 1'b1, 1'b0, 1'b1, 1'b0});
        dir_tab[17] = mk_row(REQ_HEADER, 32'h7352_4742, 31'h1, 8'h00, 1'b1,
                             result_t'{8'h00, 1'b1, 1'b0, 1'b1, 1'b0});
        dir_tab[18] = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h01, 1'b0, NO_LIT);
        dir_tab[19] = mk_row(REQ_PAYLOAD, 32'h0, 31'h0, 8'h7F, 1'b1, ERR_LIT);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_N; r++)
            send_item(dir_tab[r].it, dir_tab[r].lit_on, dir_tab[r].lit);

        while (rand_cnt < RAND_N)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 24);
                send_rand(hdr_item(31'(len)));
                repeat (len) send_rand(pay_item());
            end
            else if (pick < 88)
            begin
                len = $urandom_range(2, 10);
                send_rand(hdr_item(31'(len)));
                repeat ($urandom_range(0, len - 1)) send_rand(pay_item());
            end
            else if (pick < 94)
                repeat ($urandom_range(1, 3)) send_rand(pay_item());
            else
            begin
                send_rand(hdr_item(31'($urandom)));
                repeat ($urandom_range(0, 4)) send_rand(pay_item());
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (mism_cnt == 0 && framed_q.size() == 0)
            $display("png_chunk_framer_crc32_core regression: pass");
        else
            $display("png_chunk_framer_crc32_core regression: fail");
        $finish;
    end

endmodule
